[hw/rtl/blm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery low-charge monitor package
// Shared types, register indexes, codes and reset values for the monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

   // run counter width default
   localparam int RUN_WIDTH_DEF = 8;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_MIN_MV    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_MAX_MV    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_CHARGE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVER_MV    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYST_COUNT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHG_DEBOUNCE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LP_ENABLE     = 3'd6;

   localparam int CSR_DATA_W = 15;

   // register reset values
   localparam logic [14:0] LOW_MIN_MV_RST   = 15'd10000;
   localparam logic [14:0] LOW_MAX_MV_RST   = 15'd19500;
   localparam logic [7:0]  LOW_CHARGE_RST   = 8'd15;
   localparam logic [14:0] RECOVER_MV_RST   = 15'd19900;
   localparam logic [7:0]  HYST_COUNT_RST   = 8'd30;
   localparam logic [7:0]  CHG_DEBOUNCE_RST = 8'd10;
   localparam logic        LP_ENABLE_RST    = 1'b1;

   // low-power request modes
   localparam logic [7:0] FLAG_STANDBY = 8'h01;
   localparam logic [7:0] FLAG_SUSPEND = 8'h02;
   localparam logic [7:0] FLAG_SYNC    = 8'h03;

   // control byte bits
   localparam logic [7:0] CTL_SUPPLY_ON = 8'h01;
   localparam logic [7:0] CTL_SUPPLY_KEEP = 8'hFE;
   localparam logic [7:0] CTL_SYNC      = 8'h04;
   localparam logic [7:0] CTL_STANDBY   = 8'h08;

   // status bit forced when battery is low
   localparam logic [7:0] STATUS_LOW = 8'h02;

   typedef struct packed {
      logic [14:0] low_window_min_mv;
      logic [14:0] low_window_max_mv;
      logic [7:0]  low_charge_percent;
      logic [14:0] recover_mv;
      logic [7:0]  hysteresis_count;
      logic [7:0]  charge_debounce;
      logic        low_power_enable;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] voltage_mv;
      logic [7:0]         charge_percent;
      logic [7:0]         monitor_status;
      logic               comm_error;
      logic               request_valid;
      logic [7:0]         request_flag;
   } req_type;

   typedef struct packed {
      logic [7:0] status_out;
      logic       battery_low;
      logic       charging;
      logic       board_fault;
      logic       send_valid;
      logic [7:0] send_control;
      logic [7:0] ack_flag;
      logic       suspend_pulse;
      logic       sync_pulse;
   } rsp_type;

endpackage
`default_nettype wire

[hw/rtl/blm_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery low-charge monitor configuration registers
// Write-only register bank, loaded with the default thresholds on reset.
// ----------------------------------------------------------------------------
module blm_csr
   import blm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_window_min_mv  <= LOW_MIN_MV_RST;
         cfg_ff.low_window_max_mv  <= LOW_MAX_MV_RST;
         cfg_ff.low_charge_percent <= LOW_CHARGE_RST;
         cfg_ff.recover_mv         <= RECOVER_MV_RST;
         cfg_ff.hysteresis_count   <= HYST_COUNT_RST;
         cfg_ff.charge_debounce    <= CHG_DEBOUNCE_RST;
         cfg_ff.low_power_enable   <= LP_ENABLE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOW_MIN_MV:   cfg_ff.low_window_min_mv  <= csr_wdata[14:0];
            CSR_LOW_MAX_MV:   cfg_ff.low_window_max_mv  <= csr_wdata[14:0];
            CSR_LOW_CHARGE:   cfg_ff.low_charge_percent <= csr_wdata[7:0];
            CSR_RECOVER_MV:   cfg_ff.recover_mv         <= csr_wdata[14:0];
            CSR_HYST_COUNT:   cfg_ff.hysteresis_count   <= csr_wdata[7:0];
            CSR_CHG_DEBOUNCE: cfg_ff.charge_debounce    <= csr_wdata[7:0];
            CSR_LP_ENABLE:    cfg_ff.low_power_enable   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[hw/rtl/blm_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery low-charge monitor core
// Debounce and hysteresis state, control byte and pending request, updated
// once per request; result computed combinationally from the registered request.
// ----------------------------------------------------------------------------
module blm_core
   import blm_pkg::*;
#(
   parameter int RunWidth = RUN_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire req_type req,
   input  wire logic    advance,
   output rsp_type      rsp
);

   localparam int CmpW = (RunWidth > 8) ? RunWidth : 8;
   localparam logic [RunWidth-1:0] RunMax = {RunWidth{1'b1}};

   logic [RunWidth-1:0] chg_run_ff, chg_run_in;
   logic [RunWidth-1:0] low_run_ff, low_run_in;
   logic [RunWidth-1:0] rec_run_ff, rec_run_in;
   logic                chg_state_ff, chg_state_in;
   logic                low_state_ff, low_state_in;
   logic [7:0]          ctl_ff, ctl_in;
   logic                pend_ff, pend_in;
   logic [7:0]          pend_flag_ff, pend_flag_in;

   logic                low_mid;
   logic                in_window;
   logic                above_recover;
   logic [7:0]          ctl_sent;

   assign in_window =
      ($signed(req.voltage_mv) >= $signed({1'b0, cfg.low_window_min_mv})) &&
      ($signed(req.voltage_mv) <= $signed({1'b0, cfg.low_window_max_mv})) &&
      (req.charge_percent <= cfg.low_charge_percent);
   assign above_recover = $signed(req.voltage_mv) > $signed({1'b0, cfg.recover_mv});

   always_comb begin
      chg_run_in   = chg_run_ff;
      low_run_in   = low_run_ff;
      rec_run_in   = rec_run_ff;
      chg_state_in = chg_state_ff;
      low_mid      = low_state_ff;
      low_state_in = low_state_ff;
      ctl_in       = ctl_ff;
      pend_in      = pend_ff;
      pend_flag_in = pend_flag_ff;

      // charging debounce; a charging report also drops the low state
      if (req.monitor_status[0]) begin
         low_mid    = 1'b0;
         chg_run_in = (chg_run_ff == RunMax) ? chg_run_ff : chg_run_ff + 1'b1;
         if (CmpW'(chg_run_in) >= CmpW'(cfg.charge_debounce)) begin
            chg_state_in = 1'b1;
         end
      end else begin
         chg_run_in   = '0;
         chg_state_in = 1'b0;
      end

      // low battery hysteresis; compare uses the count before incrementing
      low_state_in = low_mid;
      if (!low_mid) begin
         if (in_window) begin
            if (CmpW'(low_run_ff) > CmpW'(cfg.hysteresis_count)) begin
               low_state_in = 1'b1;
            end
            low_run_in = (low_run_ff == RunMax) ? low_run_ff : low_run_ff + 1'b1;
         end else begin
            low_run_in = '0;
         end
      end else begin
         if (above_recover) begin
            if (CmpW'(rec_run_ff) > CmpW'(cfg.hysteresis_count)) begin
               low_state_in = 1'b0;
            end
            rec_run_in = (rec_run_ff == RunMax) ? rec_run_ff : rec_run_ff + 1'b1;
         end else begin
            rec_run_in = '0;
         end
      end

      ctl_sent = chg_state_in ? (ctl_ff & CTL_SUPPLY_KEEP) : (ctl_ff | CTL_SUPPLY_ON);
      ctl_in   = ctl_sent;

      rsp.status_out    = low_state_in ? (req.monitor_status | STATUS_LOW) : req.monitor_status;
      rsp.battery_low   = low_state_in;
      rsp.charging      = chg_state_in;
      rsp.board_fault   = req.comm_error;
      rsp.send_valid    = pend_ff;
      rsp.send_control  = pend_ff ? ctl_sent : 8'h00;
      rsp.ack_flag      = pend_ff ? pend_flag_ff : 8'h00;
      rsp.suspend_pulse = 1'b0;
      rsp.sync_pulse    = 1'b0;

      // the stored flag keeps acting even after the request is acknowledged
      if (cfg.low_power_enable) begin
         case (pend_flag_ff)
            FLAG_STANDBY: ctl_in = ctl_sent | CTL_STANDBY;
            FLAG_SUSPEND: begin
               ctl_in            = ctl_sent & CTL_SUPPLY_KEEP;
               rsp.suspend_pulse = pend_ff;
            end
            FLAG_SYNC: begin
               ctl_in         = ctl_sent | CTL_SYNC;
               rsp.sync_pulse = pend_ff;
            end
            default: ctl_in = ctl_sent;
         endcase
         pend_in = 1'b0;
      end

      if (req.request_valid) begin
         pend_flag_in = req.request_flag;
         pend_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chg_run_ff   <= '0;
         low_run_ff   <= '0;
         rec_run_ff   <= '0;
         chg_state_ff <= 1'b0;
         low_state_ff <= 1'b0;
         ctl_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_flag_ff <= '0;
      end else if (advance) begin
         chg_run_ff   <= chg_run_in;
         low_run_ff   <= low_run_in;
         rec_run_ff   <= rec_run_in;
         chg_state_ff <= chg_state_in;
         low_state_ff <= low_state_in;
         ctl_ff       <= ctl_in;
         pend_ff      <= pend_in;
         pend_flag_ff <= pend_flag_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/battery_low_charge_monitor.sv]
`default_nettype none
// Requests: an accepted request is held in the input register and moves to the
//   result register when that is empty or being taken; rsp_stall holds a
//   result in the result register, and req_stall then holds requests back.
// Throughput: one request per cycle while rsp_stall is low; the monitor state
//   updates as the request moves on to the result register.
// Reset: synchronous; clears valids and monitor state, loads default thresholds.
// ----------------------------------------------------------------------------
// Battery low-charge monitor
// Charging debounce, low-battery hysteresis and low-power request handling.
// ----------------------------------------------------------------------------
module battery_low_charge_monitor
   import blm_pkg::*;
#(
   parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [15:0]     req_voltage_mv,
   input  wire logic [7:0]             req_charge_percent,
   input  wire logic [7:0]             req_monitor_status,
   input  wire logic                   req_comm_error,
   input  wire logic                   req_request_valid,
   input  wire logic [7:0]             req_request_flag,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_status_out,
   output logic                        rsp_battery_low,
   output logic                        rsp_charging,
   output logic                        rsp_board_fault,
   output logic                        rsp_send_valid,
   output logic [7:0]                  rsp_send_control,
   output logic [7:0]                  rsp_ack_flag,
   output logic                        rsp_suspend_pulse,
   output logic                        rsp_sync_pulse,

   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type req_ff;
   rsp_type rsp_next;
   rsp_type rsp_ff;

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;
   logic rsp_load;

   blm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   blm_core #(
      .RunWidth (RUN_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_ff),
      .advance (rsp_load),
      .rsp     (rsp_next)
   );

   // result register frees up when empty or being taken
   assign rsp_load     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !(!rsp_valid_ff || !rsp_stall);
   assign req_accept   = req_valid && !req_stall;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff.voltage_mv     <= req_voltage_mv;
         req_ff.charge_percent <= req_charge_percent;
         req_ff.monitor_status <= req_monitor_status;
         req_ff.comm_error     <= req_comm_error;
         req_ff.request_valid  <= req_request_valid;
         req_ff.request_flag   <= req_request_flag;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status_out    = rsp_ff.status_out;
   assign rsp_battery_low   = rsp_ff.battery_low;
   assign rsp_charging      = rsp_ff.charging;
   assign rsp_board_fault   = rsp_ff.board_fault;
   assign rsp_send_valid    = rsp_ff.send_valid;
   assign rsp_send_control  = rsp_ff.send_control;
   assign rsp_ack_flag      = rsp_ff.ack_flag;
   assign rsp_suspend_pulse = rsp_ff.suspend_pulse;
   assign rsp_sync_pulse    = rsp_ff.sync_pulse;

endmodule
`default_nettype wire

[hw/rtl/blm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery low-charge monitor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module blm_checker
   import blm_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [7:0]             rsp_status_out,
   input wire logic                   rsp_battery_low,
   input wire logic                   rsp_charging,
   input wire logic                   rsp_send_valid,
   input wire logic [7:0]             rsp_send_control,
   input wire logic [7:0]             rsp_ack_flag,
   input wire logic                   rsp_suspend_pulse,
   input wire logic                   rsp_sync_pulse
);

   // low state must show in the status byte
   a_low_in_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_battery_low |-> rsp_status_out[1])
      else $error("battery_low without status bit 1");

   // charging is only declared on a report that says charging
   a_charging_needs_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_charging |-> rsp_status_out[0])
      else $error("charging without status bit 0");

   // nothing is sent and no pulse raised without a pending request
   a_no_send_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_valid |-> rsp_send_control == 8'h00 &&
         rsp_ack_flag == 8'h00 && !rsp_suspend_pulse && !rsp_sync_pulse)
      else $error("send fields active without send_valid");

   // a pulse matches the acknowledged mode
   a_pulse_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_suspend_pulse || rsp_sync_pulse) |->
         (rsp_suspend_pulse && rsp_ack_flag == FLAG_SUSPEND && !rsp_sync_pulse) ||
         (rsp_sync_pulse && rsp_ack_flag == FLAG_SYNC && !rsp_suspend_pulse))
      else $error("pulse does not match acknowledged flag");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status_out) &&
         $stable(rsp_send_control) && $stable(rsp_ack_flag))
      else $error("stalled result changed");

endmodule

bind battery_low_charge_monitor blm_checker u_blm_checker (.*);
`default_nettype wire

[sim/tb_battery_low_charge_monitor.sv]
// ----------------------------------------------------------------------------
// Battery low-charge monitor testbench
// Drives monitor reports through the valid/stall request channel and checks
// every response against a cycle-free model of the debounce, hysteresis and
// low-power logic. Covers directed corner cases, then shaped random runs under
// several register settings, with random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_battery_low_charge_monitor;
   import blm_pkg::*;

   typedef logic [RUN_WIDTH_DEF-1:0] run_t;
   typedef enum int {RUN_LOW, RUN_RECOVER, RUN_CHARGE, RUN_NOISE} run_kind_e;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the response to each accepted request
   // -------------------------------------------------------------------------
   class battery_report_checker;
      cfg_type    cfg;
      run_t       charge_run, low_run, recover_run;
      logic       charging_state, low_state, pending_update;
      logic [7:0] control_byte, pending_flag;
      rsp_type    expected_status[$];
      int         failures;

      function new();
         cfg = {LOW_MIN_MV_RST, LOW_MAX_MV_RST, LOW_CHARGE_RST, RECOVER_MV_RST,
                HYST_COUNT_RST, CHG_DEBOUNCE_RST, LP_ENABLE_RST};
         charge_run     = '0;
         low_run        = '0;
         recover_run    = '0;
         charging_state = 1'b0;
         low_state      = 1'b0;
         pending_update = 1'b0;
         control_byte   = '0;
         pending_flag   = '0;
         failures       = 0;
      endfunction

      function run_t bump(run_t v);
         return (&v) ? v : v + 1'b1;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx,
                                 logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LOW_MIN_MV:   cfg.low_window_min_mv  = data;
            CSR_LOW_MAX_MV:   cfg.low_window_max_mv  = data;
            CSR_LOW_CHARGE:   cfg.low_charge_percent = data[7:0];
            CSR_RECOVER_MV:   cfg.recover_mv         = data;
            CSR_HYST_COUNT:   cfg.hysteresis_count   = data[7:0];
            CSR_CHG_DEBOUNCE: cfg.charge_debounce    = data[7:0];
            CSR_LP_ENABLE:    cfg.low_power_enable   = data[0];
            default: ;
         endcase
      endfunction

      function void note_report(req_type r);
         rsp_type    e;
         int         volt;
         logic [7:0] status;
         e      = '0;
         volt   = int'(r.voltage_mv);
         status = r.monitor_status;

         if (status[0]) begin
            low_state  = 1'b0;
            charge_run = bump(charge_run);
            if (charge_run >= cfg.charge_debounce) charging_state = 1'b1;
         end else begin
            charge_run     = '0;
            charging_state = 1'b0;
         end

         // run counters are compared before they advance
         if (!low_state) begin
            if (volt >= int'(cfg.low_window_min_mv) && volt <= int'(cfg.low_window_max_mv)
                && r.charge_percent <= cfg.low_charge_percent) begin
               if (low_run > cfg.hysteresis_count) low_state = 1'b1;
               low_run = bump(low_run);
            end else begin
               low_run = '0;
            end
         end else begin
            if (volt > int'(cfg.recover_mv)) begin
               if (recover_run > cfg.hysteresis_count) low_state = 1'b0;
               recover_run = bump(recover_run);
            end else begin
               recover_run = '0;
            end
         end

         if (low_state) status |= STATUS_LOW;

         if (charging_state) control_byte &= CTL_SUPPLY_KEEP;
         else control_byte |= CTL_SUPPLY_ON;

         if (pending_update) begin
            e.send_valid   = 1'b1;
            e.send_control = control_byte;
            e.ack_flag     = pending_flag;
         end

         // the stored flag keeps acting on the control byte while enabled
         if (cfg.low_power_enable) begin
            case (pending_flag)
               FLAG_STANDBY: control_byte |= CTL_STANDBY;
               FLAG_SUSPEND: begin
                  control_byte    &= CTL_SUPPLY_KEEP;
                  e.suspend_pulse  = pending_update;
               end
               FLAG_SYNC: begin
                  control_byte |= CTL_SYNC;
                  e.sync_pulse  = pending_update;
               end
               default: ;
            endcase
            pending_update = 1'b0;
         end

         if (r.request_valid) begin
            pending_flag   = r.request_flag;
            pending_update = 1'b1;
         end

         e.status_out  = status;
         e.battery_low = low_state;
         e.charging    = charging_state;
         e.board_fault = r.comm_error;
         expected_status.push_back(e);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("mismatch at %0t: %s", $time, msg);
      endfunction

      function void compare(string name, logic [7:0] exp_v, logic [7:0] act_v);
         if (act_v !== exp_v)
            note_failure($sformatf("%s expected %02h got %02h", name, exp_v, act_v));
      endfunction

      function void check_status(rsp_type got);
         rsp_type e;
         if (expected_status.size() == 0) begin
            note_failure($sformatf("response with none outstanding, status_out %02h",
                                   got.status_out));
            return;
         end
         e = expected_status.pop_front();
         compare("status_out",    e.status_out,    got.status_out);
         compare("battery_low",   e.battery_low,   got.battery_low);
         compare("charging",      e.charging,      got.charging);
         compare("board_fault",   e.board_fault,   got.board_fault);
         compare("send_valid",    e.send_valid,    got.send_valid);
         compare("send_control",  e.send_control,  got.send_control);
         compare("ack_flag",      e.ack_flag,      got.ack_flag);
         compare("suspend_pulse", e.suspend_pulse, got.suspend_pulse);
         compare("sync_pulse",    e.sync_pulse,    got.sync_pulse);
      endfunction

      function int failure_total();
         return failures + expected_status.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid          = 1'b0;
   logic              req_stall;
   logic signed [15:0] req_voltage_mv    = '0;
   logic [7:0]        req_charge_percent = '0;
   logic [7:0]        req_monitor_status = '0;
   logic              req_comm_error     = 1'b0;
   logic              req_request_valid  = 1'b0;
   logic [7:0]        req_request_flag   = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic [7:0]        rsp_status_out;
   logic              rsp_battery_low;
   logic              rsp_charging;
   logic              rsp_board_fault;
   logic              rsp_send_valid;
   logic [7:0]        rsp_send_control;
   logic [7:0]        rsp_ack_flag;
   logic              rsp_suspend_pulse;
   logic              rsp_sync_pulse;

   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LOW_MIN_MV;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   battery_report_checker sb = new();

   int req_idle_pct = 35;
   int rsp_idle_pct = 35;
   bit hold_request = 1'b0;
   int hold_left    = 0;

   battery_low_charge_monitor i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_voltage_mv     (req_voltage_mv),
      .req_charge_percent (req_charge_percent),
      .req_monitor_status (req_monitor_status),
      .req_comm_error     (req_comm_error),
      .req_request_valid  (req_request_valid),
      .req_request_flag   (req_request_flag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status_out     (rsp_status_out),
      .rsp_battery_low    (rsp_battery_low),
      .rsp_charging       (rsp_charging),
      .rsp_board_fault    (rsp_board_fault),
      .rsp_send_valid     (rsp_send_valid),
      .rsp_send_control   (rsp_send_control),
      .rsp_ack_flag       (rsp_ack_flag),
      .rsp_suspend_pulse  (rsp_suspend_pulse),
      .rsp_sync_pulse     (rsp_sync_pulse),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = 150;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : response_monitor
      rsp_type got;
      got = {rsp_status_out, rsp_battery_low, rsp_charging, rsp_board_fault,
             rsp_send_valid, rsp_send_control, rsp_ack_flag,
             rsp_suspend_pulse, rsp_sync_pulse};
      if (!reset && rsp_valid && !rsp_stall) sb.check_status(got);
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------
   task automatic offer(input req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_voltage_mv     <= r.voltage_mv;
      req_charge_percent <= r.charge_percent;
      req_monitor_status <= r.monitor_status;
      req_comm_error     <= r.comm_error;
      req_request_valid  <= r.request_valid;
      req_request_flag   <= r.request_flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_report(r);
   endtask

   task automatic offer_fields(input int volt, input int soc, input int status,
                               input bit cerr, input bit rv, input int flag);
      req_type r;
      r.voltage_mv     = 16'(volt);
      r.charge_percent = 8'(soc);
      r.monitor_status = 8'(status);
      r.comm_error     = cerr;
      r.request_valid  = rv;
      r.request_flag   = 8'(flag);
      offer(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(CSR_LOW_MIN_MV,   c.low_window_min_mv);
      write_reg(CSR_LOW_MAX_MV,   c.low_window_max_mv);
      write_reg(CSR_LOW_CHARGE,   c.low_charge_percent);
      write_reg(CSR_RECOVER_MV,   c.recover_mv);
      write_reg(CSR_HYST_COUNT,   c.hysteresis_count);
      write_reg(CSR_CHG_DEBOUNCE, c.charge_debounce);
      write_reg(CSR_LP_ENABLE,    c.low_power_enable);
      csr_we <= 1'b0;
   endtask

   function automatic int span(input int lo, input int hi);
      if (hi < lo) return $urandom;
      return $urandom_range(hi, lo);
   endfunction

   function automatic req_type shaped_report(input run_kind_e kind);
      req_type r;
      r.voltage_mv     = 16'($urandom);
      r.charge_percent = 8'($urandom);
      r.monitor_status = 8'($urandom);
      r.comm_error     = 1'($urandom);
      r.request_valid  = ($urandom_range(3) == 0);
      r.request_flag   = 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
      case (kind)
         RUN_LOW: begin
            r.voltage_mv        = 16'(span(sb.cfg.low_window_min_mv,
                                           sb.cfg.low_window_max_mv));
            r.charge_percent    = 8'($urandom_range(sb.cfg.low_charge_percent));
            r.monitor_status[0] = ($urandom_range(15) == 0);
         end
         RUN_RECOVER: begin
            r.voltage_mv        = 16'(span(int'(sb.cfg.recover_mv) + 1, 32767));
            r.monitor_status[0] = ($urandom_range(15) == 0);
         end
         RUN_CHARGE: r.monitor_status[0] = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   // runs of like reports, some long enough to pass the hysteresis count
   task automatic random_reports(input int count);
      int        sent;
      int        len;
      run_kind_e kind;
      sent = 0;
      while (sent < count) begin
         kind = run_kind_e'($urandom_range(3));
         if ($urandom_range(2) == 0) len = int'(sb.cfg.hysteresis_count) + 2 + $urandom_range(2);
         else len = $urandom_range(8, 1);
         repeat (len) begin
            offer(shaped_report(kind));
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes and request handling under the reset settings
      offer_fields(-32768, 0,   8'h00, 0, 1, FLAG_STANDBY);
      offer_fields(32767,  255, 8'hFF, 1, 0, 8'hFF);
      offer_fields(10000,  15,  8'hFE, 0, 1, FLAG_SUSPEND);
      offer_fields(19500,  0,   8'h00, 1, 1, FLAG_SYNC);
      offer_fields(9999,   16,  8'h00, 0, 1, 8'h00);
      offer_fields(19501,  15,  8'h80, 0, 1, 8'hFF);
      offer_fields(-1,     0,   8'h01, 1, 0, 8'h00);
      offer_fields(0,      255, 8'h7F, 0, 1, 8'h04);
      drain();

      // disabled: request resent each time, a newer one overwrites the stored one
      write_reg(CSR_LP_ENABLE, 1'b0);
      csr_we <= 1'b0;
      offer_fields(15000, 5, 8'h00, 0, 1, FLAG_SUSPEND);
      offer_fields(15000, 5, 8'h00, 0, 1, FLAG_SYNC);
      offer_fields(15000, 5, 8'h00, 0, 0, 8'h00);
      offer_fields(15000, 5, 8'h00, 0, 0, 8'h00);
      drain();
      write_reg(CSR_LP_ENABLE, 1'b1);
      csr_we <= 1'b0;
      offer_fields(15000, 5, 8'h00, 0, 0, 8'h00);
      drain();

      // zero hysteresis and zero debounce; counters carry over between states
      c = {LOW_MIN_MV_RST, LOW_MAX_MV_RST, LOW_CHARGE_RST, RECOVER_MV_RST,
           8'd0, 8'd0, 1'b1};
      load_settings(c);
      offer_fields(12000, 10, 8'h00, 0, 0, 8'h00);
      offer_fields(12000, 10, 8'h00, 0, 0, 8'h00);
      offer_fields(20000, 50, 8'h00, 0, 0, 8'h00);
      offer_fields(20000, 50, 8'h00, 0, 0, 8'h00);
      offer_fields(12000, 10, 8'h01, 0, 0, 8'h00);
      offer_fields(12000, 10, 8'h00, 0, 0, 8'h00);
      offer_fields(20000, 50, 8'h00, 0, 0, 8'h00);
      drain();

      // typical thresholds, short hysteresis
      c.low_window_min_mv  = 15'($urandom_range(14000, 8000));
      c.low_window_max_mv  = 15'($urandom_range(20000, 15000));
      c.low_charge_percent = 8'($urandom_range(60, 10));
      c.recover_mv         = 15'($urandom_range(22000, 18000));
      c.hysteresis_count   = 8'($urandom_range(5));
      c.charge_debounce    = 8'($urandom_range(5));
      c.low_power_enable   = 1'b1;
      load_settings(c);
      random_reports(150);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_reports(150);
      // hold the output back while requests keep coming
      hold_request = 1'b1;
      random_reports(40);
      req_idle_pct = 35;
      rsp_idle_pct = 35;
      drain();

      // every register random
      c.low_window_min_mv  = 15'($urandom);
      c.low_window_max_mv  = 15'($urandom);
      c.low_charge_percent = 8'($urandom);
      c.recover_mv         = 15'($urandom);
      c.hysteresis_count   = 8'($urandom_range(12));
      c.charge_debounce    = 8'($urandom);
      c.low_power_enable   = 1'($urandom);
      load_settings(c);
      random_reports(250);
      drain();

      // upper extremes: counters run into saturation
      c = {15'h7FFF, 15'h0000, 8'hFF, 15'h7FFF, 8'd254, 8'd255, 1'b1};
      c.low_window_min_mv = 15'h0000;
      c.low_window_max_mv = 15'h7FFF;
      load_settings(c);
      random_reports(300);
      drain();

      // lower extremes, requests held back
      c = {15'h7FFF, 15'h7FFF, 8'h00, 15'h0000, 8'd255, 8'd1, 1'b0};
      load_settings(c);
      random_reports(150);
      drain();

      c = {15'h0000, 15'h0000, 8'h00, 15'h0000, 8'd0, 8'd0, 1'b1};
      load_settings(c);
      random_reports(150);
      drain();

      c = {LOW_MIN_MV_RST, LOW_MAX_MV_RST, LOW_CHARGE_RST, RECOVER_MV_RST,
           HYST_COUNT_RST, CHG_DEBOUNCE_RST, LP_ENABLE_RST};
      load_settings(c);
      random_reports(150);
      drain();

      if (sb.failure_total() == 0) begin
         $display("battery_low_charge_monitor regression: pass");
      end else begin
         $display("battery_low_charge_monitor regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("battery_low_charge_monitor regression: fail");
      $finish;
   end

endmodule
